// File: rtl/core/sha256_stream_hash_unit_macros.svh
// Assertion macros for the SHA-256 stream hash unit.
// Depends on nothing; included by modules that assert.
`ifndef SHA256_STREAM_HASH_UNIT_MACROS_SVH
`define SHA256_STREAM_HASH_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SHU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SHU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: rtl/core/sha_pkg.sv
// Package for the SHA-256 stream hash unit: constants, round table, helpers.
// Depends on nothing.
package sha_pkg;
   localparam int BlockBytes = 64;
   localparam int RoundCount = 64;
   localparam logic [7:0] PadByte = 8'h80;

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   typedef struct packed {
      logic start;   // begin compressing the 16 loaded words
      logic busy;
      logic done;    // one-cycle pulse after the chain update
   } core_ctl_type;
endpackage

// File: rtl/core/sha_round_core.sv
// SHA-256 compression engine: one round per cycle on a 16-word schedule window.
// Depends on sha_pkg.
`include "sha256_stream_hash_unit_macros.svh"
module sha_round_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                load_we,
   input  logic [31:0]         load_word,
   input  logic                chain_init,
   input  logic [2:0]          rd_idx,
   output logic [31:0]         rd_word,
   output sha_pkg::core_ctl_type ctl
);
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [6:0]  rnd_ff, rnd_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] s0, s1, wnew, t1, t2, ch, maj, bs0, bs1;

   always_comb begin
      s0 = sha_pkg::ror(w_ff[1], 7) ^ sha_pkg::ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::ror(w_ff[14], 17) ^ sha_pkg::ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      bs1 = sha_pkg::ror(v_ff[4], 6) ^ sha_pkg::ror(v_ff[4], 11) ^ sha_pkg::ror(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + bs1 + ch + sha_pkg::RoundK[rnd_ff[5:0]] + w_ff[0];
      bs0 = sha_pkg::ror(v_ff[0], 2) ^ sha_pkg::ror(v_ff[0], 13) ^ sha_pkg::ror(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = bs0 + maj;
      busy_in = busy_ff;
      rnd_in = rnd_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         rnd_in = '0;
      end else if (busy_ff) begin
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'(sha_pkg::RoundCount)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff <= rnd_in;
      end
   end

   // Schedule window: shift in bytes-words while loading, advance per round.
   always_ff @(posedge clock) begin
      if (load_we) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= load_word;
      end else if (busy_ff && rnd_ff < 7'(sha_pkg::RoundCount)) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnew;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || chain_init) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::init_h(3'(i));
      end else if (start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (busy_ff && rnd_ff < 7'(sha_pkg::RoundCount)) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else if (busy_ff) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   assign rd_word = h_ff[rd_idx];
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;

   `SHU_ASSERT_IMP(a_no_restart, clock, reset, busy_ff, !start, "start while busy")
   `SHU_ASSERT_NEXT(a_done_end, clock, reset, busy_ff && rnd_ff == 7'd64, done_ff && !busy_ff,
      "round count end without done")
   `SHU_ASSERT_IMP(a_no_load, clock, reset, busy_ff, !load_we, "load during rounds")
endmodule

// File: rtl/core/sha256_stream_hash_unit.sv
// SHA-256 stream hash unit: gathers message bytes, pads and compresses, emits digest.
// Depends on sha_pkg, sha_round_core and the assertion macro header.
// The unit takes one beat per accept and then drops req_ready until that beat's
// work is done. A beat that neither fills nor closes the block passes through
// StStep: shift in and count, then ready again. So beats cannot be taken back to back.
// Message bytes shift into a 64-byte register in arrival order. The 64th byte
// starts a block: StLoad moves the 16 words into the round engine, then come a
// start, 64 rounds at one per cycle, the chain update and done; then req_ready returns.
// A closing beat first shifts in the padding at one byte per cycle: 0x80, then
// zeros, and in the final block the 64-bit bit length, until the block is full;
// then the block run follows. When 56 or more bytes are held, the padding spills
// into a second block, which takes another pad pass and another block run.
// The eight digest words then go out on rsp_ one per beat, H0 first. Each word
// is held until rsp_ready. After the eighth word is taken, the chain returns to
// the initial values and req_ready rises again.
`include "sha256_stream_hash_unit_macros.svh"
module sha256_stream_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StLoad = 3'd1;  // move 16 words into the engine
   localparam logic [2:0] StRun  = 3'd2;
   localparam logic [2:0] StOut  = 3'd3;
   localparam logic [2:0] StStep = 3'd4;  // byte stored, return ready
   localparam logic [2:0] StPad  = 3'd5;  // shift in one padding byte per cycle

   logic [2:0]  st_ff, st_in;
   logic [7:0]  blk_ff [64];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic        closing_ff, closing_in;   // pad mode active
   logic        second_ff, second_in;     // current pad block is the second
   logic        twoblk_ff, twoblk_in;
   logic        mark_ff, mark_in;         // 0x80 still to be shifted in
   logic        pend_end_ff, pend_end_in; // full block also closes the message
   logic [3:0]  ld_ff, ld_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        start, load_we, chain_init, accept;
   logic        shift_byte, shift_word;
   logic [7:0]  shift_data, pad_data;
   logic [31:0] load_word, rd_word;
   logic [63:0] bits;
   sha_pkg::core_ctl_type ctl;

   assign accept = req_valid && req_ready;
   assign req_ready = (st_ff == StIdle);
   assign bits = {total_ff, 3'b000};

   // Once the block is full, the oldest four bytes sit at the bottom of the shift register.
   assign load_word = {blk_ff[0], blk_ff[1], blk_ff[2], blk_ff[3]};

   always_comb begin
      st_in = st_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      closing_in = closing_ff;
      second_in = second_ff;
      twoblk_in = twoblk_ff;
      mark_in = mark_ff;
      pend_end_in = pend_end_ff;
      ld_in = ld_ff;
      oidx_in = oidx_ff;
      load_we = 1'b0;
      start = 1'b0;
      chain_init = 1'b0;
      shift_byte = 1'b0;
      shift_word = 1'b0;
      // Padding byte for the position the next shift fills.
      pad_data = 8'h00;
      if (mark_ff) begin
         pad_data = sha_pkg::PadByte;
      end else if ((second_ff || !twoblk_ff) && fill_ff >= 6'd56) begin
         pad_data = bits[8 * (7 - int'(fill_ff[2:0])) +: 8];
      end
      shift_data = (st_ff == StPad) ? pad_data : req_data_byte;
      case (st_ff)
         StIdle: begin
            if (accept) begin
               if (req_byte_present) begin
                  shift_byte = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  total_in = total_ff + 61'd1;
               end
               pend_end_in = req_message_end;
               closing_in = req_message_end;
               second_in = 1'b0;
               mark_in = 1'b1;
               ld_in = '0;
               twoblk_in = (req_byte_present ? fill_ff + 6'd1 : fill_ff) >= 6'd56;
               if (req_byte_present && fill_ff == 6'd63) begin
                  closing_in = 1'b0;
                  st_in = StLoad;
               end else if (req_message_end) begin
                  st_in = StPad;
               end else begin
                  st_in = StStep;
               end
            end
         end
         StStep: st_in = StIdle;
         StPad: begin
            shift_byte = 1'b1;
            mark_in = 1'b0;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) st_in = StLoad;
         end
         StLoad: begin
            load_we = 1'b1;
            shift_word = 1'b1;
            ld_in = ld_ff + 4'd1;
            if (ld_ff == 4'd15) st_in = StRun;
         end
         StRun: begin
            if (!ctl.busy && !ctl.done && ld_ff == 4'd0) begin
               start = 1'b1;
               ld_in = 4'd1;  // mark engine launched
            end else if (ctl.done) begin
               ld_in = '0;
               if (!closing_ff) begin
                  // A full block that also ends the message still needs padding.
                  if (pend_end_ff) begin
                     closing_in = 1'b1;
                     twoblk_in = 1'b0;
                     mark_in = 1'b1;
                     st_in = StPad;
                  end else begin
                     st_in = StIdle;
                  end
               end else if (twoblk_ff && !second_ff) begin
                  second_in = 1'b1;
                  st_in = StPad;
               end else begin
                  oidx_in = '0;
                  st_in = StOut;
               end
            end
         end
         StOut: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  chain_init = 1'b1;
                  fill_in = '0;
                  total_in = '0;
                  closing_in = 1'b0;
                  st_in = StIdle;
               end
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         fill_ff <= '0;
         total_ff <= '0;
         closing_ff <= 1'b0;
         second_ff <= 1'b0;
         twoblk_ff <= 1'b0;
         mark_ff <= 1'b0;
         ld_ff <= '0;
         oidx_ff <= '0;
         pend_end_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         closing_ff <= closing_in;
         second_ff <= second_in;
         twoblk_ff <= twoblk_in;
         mark_ff <= mark_in;
         ld_ff <= ld_in;
         oidx_ff <= oidx_in;
         pend_end_ff <= pend_end_in;
      end
   end

   // Block shift register: advance one byte per message or pad byte, four per load.
   always_ff @(posedge clock) begin
      if (shift_byte) begin
         for (int i = 0; i < 63; i++) blk_ff[i] <= blk_ff[i + 1];
         blk_ff[63] <= shift_data;
      end else if (shift_word) begin
         for (int i = 0; i < 60; i++) blk_ff[i] <= blk_ff[i + 4];
      end
   end

   sha_round_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .load_we    (load_we),
      .load_word  (load_word),
      .chain_init (chain_init),
      .rd_idx     (oidx_ff),
      .rd_word    (rd_word),
      .ctl        (ctl)
   );

   assign rsp_valid = (st_ff == StOut);
   assign rsp_digest_word = rd_word;
   assign rsp_word_index = oidx_ff;
   assign rsp_last_word = (oidx_ff == 3'd7);

   `SHU_ASSERT_IMP(a_out_idle, clock, reset, rsp_valid, !req_ready, "digest while taking bytes")
   `SHU_ASSERT_IMP(a_run_busy, clock, reset, ctl.busy, st_ff == StRun, "engine busy out of run")
   `SHU_ASSERT_NEXT(a_last_ret, clock, reset, rsp_valid && rsp_ready && rsp_last_word,
      req_ready && fill_ff == 6'd0, "no return after digest")
endmodule
